// ===== design/e2e_pkg.sv =====
// Package for the end-to-end frame checker.
// Holds the frame layout constants, fail codes and the frame record type.
// No dependencies; imported by every module of the block.
package e2e_pkg;

    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 32;
    localparam int INDEX_W   = 3;
    localparam int FAIL_W    = 2;

    // Position of the checksum byte, which closes a six-byte frame.
    localparam logic [INDEX_W-1:0] FRAME_LAST = 3'd5;
    localparam logic [INDEX_W-1:0] FRAME_CMD  = 3'd0;

    // Fail codes reported with each frame.
    localparam logic [FAIL_W-1:0] FAIL_NONE = 2'd0;
    localparam logic [FAIL_W-1:0] FAIL_SUM  = 2'd1;
    localparam logic [FAIL_W-1:0] FAIL_LOW  = 2'd2;
    localparam logic [FAIL_W-1:0] FAIL_HIGH = 2'd3;

    // A counter this far ahead of the expected value or more is too high.
    localparam logic [COUNT_W:0] AHEAD_LIMIT = 33'd2;

    // One assembled frame, handed from the assembler to the checker.
    typedef struct packed {
        logic               cmd_safe;
        logic               sum_ok;
        logic [COUNT_W-1:0] count;
    } frame_t;

endpackage

// ===== design/e2e_assemble.sv =====
// Frame assembler: takes one byte per transfer and builds a six-byte frame.
// Registers the finished frame (checksum result, counter, command flag).
// Depends on e2e_pkg.
module e2e_assemble (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [e2e_pkg::BYTE_W-1:0]    rx_byte,
    output logic                          frame_valid,
    output e2e_pkg::frame_t               frame,
    input  logic                          frame_take
);
    import e2e_pkg::*;

    logic [INDEX_W-1:0] byte_index_reg, byte_index_next;
    logic [BYTE_W-1:0]  sum_reg, sum_next;
    logic [BYTE_W-1:0]  cmd_reg, cmd_next;
    logic [COUNT_W-1:0] shift_reg, shift_next;
    logic               frame_valid_reg, frame_valid_next;
    frame_t             frame_reg, frame_next;
    logic               last_byte;
    logic               slot_free;
    logic               accept;

    // The final byte needs a free frame slot; other bytes are always taken.
    assign last_byte = (byte_index_reg >= FRAME_LAST);
    assign slot_free = !frame_valid_reg || frame_take;
    assign in_ready  = !last_byte || slot_free;
    assign accept    = in_valid && in_ready;

    // Byte accumulation and frame formation.
    always_comb
    begin
        byte_index_next  = byte_index_reg;
        sum_next         = sum_reg;
        cmd_next         = cmd_reg;
        shift_next       = shift_reg;
        frame_valid_next = frame_valid_reg && !frame_take;
        frame_next       = frame_reg;
        if (accept)
        begin
            if (!last_byte)
            begin
                if (byte_index_reg == FRAME_CMD)
                begin
                    cmd_next = rx_byte;
                end
                else
                begin
                    shift_next = {shift_reg[COUNT_W-BYTE_W-1:0], rx_byte};
                end
                sum_next        = sum_reg + rx_byte;
                byte_index_next = byte_index_reg + 1'b1;
            end
            else
            begin
                frame_next.cmd_safe = (cmd_reg == '0);
                frame_next.sum_ok   = (rx_byte == sum_reg);
                frame_next.count    = shift_reg;
                frame_valid_next    = 1'b1;
                byte_index_next     = '0;
                sum_next            = '0;
                cmd_next            = '0;
                shift_next          = '0;
            end
        end
    end

    // Control and frame state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg  <= '0;
            sum_reg         <= '0;
            cmd_reg         <= '0;
            shift_reg       <= '0;
            frame_valid_reg <= 1'b0;
        end
        else
        begin
            byte_index_reg  <= byte_index_next;
            sum_reg         <= sum_next;
            cmd_reg         <= cmd_next;
            shift_reg       <= shift_next;
            frame_valid_reg <= frame_valid_next;
        end
    end

    // Frame payload needs no reset.
    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

    assign frame_valid = frame_valid_reg;
    assign frame       = frame_reg;

    // The frame position never leaves the six-byte range.
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_index_reg <= FRAME_LAST)
        else $error("frame position out of range");

    // A waiting frame is held until the checker takes it.
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid_reg && !frame_take |=> frame_valid_reg && $stable(frame_reg))
        else $error("pending frame lost or changed");

    // Accepting a closing byte always produces a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |=> frame_valid_reg && byte_index_reg == FRAME_CMD)
        else $error("closing byte did not produce a frame");

endmodule

// ===== design/e2e_check.sv =====
// Frame checker: checksum and counter checks, expected counter, safe latch.
// Holds the result register that drives the output channel.
// Depends on e2e_pkg.
module e2e_check (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          frame_valid,
    input  e2e_pkg::frame_t               frame,
    output logic                          frame_take,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          frame_ok,
    output logic [e2e_pkg::FAIL_W-1:0]    fail_code,
    output logic [e2e_pkg::COUNT_W-1:0]   received_count,
    output logic                          commanded_safe,
    output logic                          safe_state,
    output logic                          kick_watchdog
);
    import e2e_pkg::*;

    logic [COUNT_W-1:0] expected_reg, expected_next;
    logic               safe_reg, safe_next;
    logic               out_valid_reg, out_valid_next;
    logic               ok_reg, ok_next;
    logic [FAIL_W-1:0]  code_reg, code_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               cmd_safe_reg, cmd_safe_next;
    logic               too_low;
    logic               too_high;

    // A frame moves on when the result register is empty or being drained.
    assign frame_take = frame_valid && (!out_valid_reg || out_ready);

    // Counter compares; the ahead test runs in 33 bits so it cannot wrap.
    assign too_low  = (frame.count < expected_reg);
    assign too_high = ({1'b0, frame.count} >= ({1'b0, expected_reg} + AHEAD_LIMIT));

    always_comb
    begin
        expected_next  = expected_reg;
        safe_next      = safe_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ok_next        = ok_reg;
        code_next      = code_reg;
        count_next     = count_reg;
        cmd_safe_next  = cmd_safe_reg;
        if (frame_take)
        begin
            ok_next = 1'b0;
            if (!frame.sum_ok)
            begin
                code_next = FAIL_SUM;
            end
            else if (too_low)
            begin
                code_next = FAIL_LOW;
            end
            else if (too_high)
            begin
                code_next     = FAIL_HIGH;
                expected_next = frame.count;
            end
            else
            begin
                code_next     = FAIL_NONE;
                ok_next       = 1'b1;
                expected_next = expected_reg + 1'b1;
            end
            count_next     = frame.count;
            cmd_safe_next  = frame.cmd_safe;
            safe_next      = safe_reg || !ok_next || frame.cmd_safe;
            out_valid_next = 1'b1;
        end
    end

    // Control state, including the sticky safe latch.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg  <= '0;
            safe_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            expected_reg  <= expected_next;
            safe_reg      <= safe_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        ok_reg       <= ok_next;
        code_reg     <= code_next;
        count_reg    <= count_next;
        cmd_safe_reg <= cmd_safe_next;
    end

    assign out_valid      = out_valid_reg;
    assign frame_ok       = ok_reg;
    assign fail_code      = code_reg;
    assign received_count = count_reg;
    assign commanded_safe = cmd_safe_reg;
    assign safe_state     = safe_reg;
    assign kick_watchdog  = !safe_reg;

    // Once set, the safe latch stays set until reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        safe_reg |=> safe_reg)
        else $error("safe latch cleared");

    // A result marked ok carries the ok code, and the reverse.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (ok_reg == (code_reg == FAIL_NONE)))
        else $error("ok flag and fail code disagree");

    // A failed or safe-commanded result always shows the safe state.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (!ok_reg || cmd_safe_reg) |-> safe_reg)
        else $error("failure did not set the safe latch");

    // The expected counter only moves when a frame is checked.
    assert property (@(posedge clk) disable iff (!rst_n)
        !frame_take |=> $stable(expected_reg))
        else $error("expected counter moved without a frame");

endmodule

// ===== design/e2e_frame_checker_top.sv =====
// Top level of the end-to-end frame checker.
// Instantiates the frame assembler and the checker; depends on e2e_pkg.
//
//   Channel  Signals                                      Direction
//   input    in_valid, in_ready, rx_byte                  byte stream in
//   output   out_valid, out_ready, frame_ok, fail_code,   one result per frame
//            received_count, commanded_safe, safe_state,
//            kick_watchdog
//
// One byte is taken per cycle; every sixth byte closes a frame and yields one result.
// The closing byte loads the frame register; the result register loads from it when the checker takes the frame.
// Reset clears the frame position, the expected counter (to zero) and the safe latch.
// When the output stalls, bytes keep flowing until a closing byte finds both the frame
// register and the result register full; only that byte waits.
module e2e_frame_checker_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [e2e_pkg::BYTE_W-1:0]      rx_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            frame_ok,
    output logic [e2e_pkg::FAIL_W-1:0]      fail_code,
    output logic [e2e_pkg::COUNT_W-1:0]     received_count,
    output logic                            commanded_safe,
    output logic                            safe_state,
    output logic                            kick_watchdog
);
    import e2e_pkg::*;

    logic   frame_valid;
    logic   frame_take;
    frame_t frame;

    // Byte stream to frame record.
    e2e_assemble u_assemble (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .frame_valid (frame_valid),
        .frame       (frame),
        .frame_take  (frame_take)
    );

    // Frame checks and result.
    e2e_check u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .frame_valid    (frame_valid),
        .frame          (frame),
        .frame_take     (frame_take),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .frame_ok       (frame_ok),
        .fail_code      (fail_code),
        .received_count (received_count),
        .commanded_safe (commanded_safe),
        .safe_state     (safe_state),
        .kick_watchdog  (kick_watchdog)
    );

endmodule

// ===== bench/tb_e2e_frame_checker_top.sv =====
// Testbench for e2e_frame_checker_top: streams six-byte frames, predicts each verdict.
// The scoreboard tracks frame assembly, counter and safe latch; depends on e2e_pkg.
// Sender bursts and receiver stalls vary at random; every verdict field is compared.
module tb_e2e_frame_checker_top;
    timeunit 1ns;
    timeprecision 1ps;

    import e2e_pkg::*;

    // One expected or observed frame verdict.
    typedef struct {
        logic               ok;
        logic [FAIL_W-1:0]  code;
        logic [COUNT_W-1:0] count;
        logic               cmd_safe;
        logic               safe;
        logic               kick;
    } verdict_t;

    // Receiver stall modes and random frame flavors.
    typedef enum int {RX_ALWAYS, RX_PATTERN, RX_RANDOM, RX_SPARSE} rx_mode_t;
    typedef enum int {FR_PASS, FR_LOW, FR_HIGH, FR_TOP, FR_BAD_SUM, FR_NOISE} frame_kind_t;

    // Tracks the frame checker's state and the verdicts still owed by the block.
    class e2e_verdict_board;
        bit [INDEX_W-1:0] byte_pos;
        bit [BYTE_W-1:0]  sum;
        bit [BYTE_W-1:0]  cmd;
        bit [COUNT_W-1:0] count_sr;
        bit [COUNT_W-1:0] exp_counter;
        bit               safe_latch;
        verdict_t         owed[$];
        int               errors;

        // Folds one accepted byte into the frame; the closing byte yields a verdict.
        function void take_byte(bit [BYTE_W-1:0] b);
            verdict_t v;
            if (byte_pos < FRAME_LAST)
            begin
                if (byte_pos == FRAME_CMD)
                    cmd = b;
                else
                    count_sr = {count_sr[COUNT_W-BYTE_W-1:0], b};
                sum = sum + b;
                byte_pos = byte_pos + 1'b1;
                return;
            end
            v.ok = 1'b0;
            v.count = count_sr;
            // Checksum first, then the counter window of expected and expected plus one.
            if (b != sum)
                v.code = FAIL_SUM;
            else if (count_sr < exp_counter)
                v.code = FAIL_LOW;
            else if ({1'b0, count_sr} >= {1'b0, exp_counter} + AHEAD_LIMIT)
            begin
                v.code = FAIL_HIGH;
                exp_counter = count_sr;
            end
            else
            begin
                v.code = FAIL_NONE;
                v.ok = 1'b1;
                exp_counter = exp_counter + 1'b1;
            end
            v.cmd_safe = (cmd == 8'd0);
            if (!v.ok || v.cmd_safe)
                safe_latch = 1'b1;
            v.safe = safe_latch;
            v.kick = !safe_latch;
            owed.push_back(v);
            byte_pos = '0;
            sum = '0;
            cmd = '0;
            count_sr = '0;
        endfunction

        function void match_field(string fname, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch: expected %0h, actual %0h",
                         $time, fname, want, got);
                errors++;
            end
        endfunction

        // Compares one transfer from the block with the oldest owed verdict.
        function void compare_verdict(verdict_t got);
            verdict_t want;
            if (owed.size() == 0)
            begin
                $display("%0t: verdict with none expected: expected nothing, %s",
                         $time, "actual:");
                $display("%0t:     ok=%0b code=%0d count=%0h",
                         $time, got.ok, got.code, got.count);
                errors++;
                return;
            end
            want = owed.pop_front();
            match_field("frame_ok", 32'(want.ok), 32'(got.ok));
            match_field("fail_code", 32'(want.code), 32'(got.code));
            match_field("received_count", want.count, got.count);
            match_field("commanded_safe", 32'(want.cmd_safe), 32'(got.cmd_safe));
            match_field("safe_state", 32'(want.safe), 32'(got.safe));
            match_field("kick_watchdog", 32'(want.kick), 32'(got.kick));
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [BYTE_W-1:0]   rx_byte;
    logic                out_valid;
    logic                out_ready;
    logic                frame_ok;
    logic [FAIL_W-1:0]   fail_code;
    logic [COUNT_W-1:0]  received_count;
    logic                commanded_safe;
    logic                safe_state;
    logic                kick_watchdog;

    e2e_verdict_board board = new();

    int       bytes_sent = 0;
    int       burst_left = 0;
    bit       gaps_on = 1'b1;
    rx_mode_t rx_mode = RX_ALWAYS;
    int       rx_mode_left = 0;
    bit [15:0] rx_pattern = 16'h00ff;

    e2e_frame_checker_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .frame_ok       (frame_ok),
        .fail_code      (fail_code),
        .received_count (received_count),
        .commanded_safe (commanded_safe),
        .safe_state     (safe_state),
        .kick_watchdog  (kick_watchdog)
    );

    // Clock generation, 10 ns period.
    always #5 clk = ~clk;

    // Receiver readiness follows a random stall mode that is redrawn when its random run length runs out.
    always @(negedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(50, 300);
            rx_pattern = 16'($urandom) | 16'h0001;
        end
        else
            rx_mode_left--;
        case (rx_mode)
            RX_ALWAYS:  out_ready = 1'b1;
            RX_PATTERN:
            begin
                rx_pattern = {rx_pattern[14:0], rx_pattern[15]};
                out_ready = rx_pattern[0];
            end
            RX_RANDOM:  out_ready = ($urandom_range(0, 3) != 0);
            default:    out_ready = ($urandom_range(0, 9) == 0);
        endcase
    end

    // Each output transfer is checked at the rising edge.
    always @(posedge clk)
    begin
        verdict_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.ok = frame_ok;
            got.code = fail_code;
            got.count = received_count;
            got.cmd_safe = commanded_safe;
            got.safe = safe_state;
            got.kick = kick_watchdog;
            board.compare_verdict(got);
        end
    end

    // Sends one byte, inserting a random gap at the start of each burst while gaps are on.
    task automatic push_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if ($urandom_range(0, 149) == 0)
            gaps_on = !gaps_on;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on)
            begin
                gap = $urandom_range(1, 8);
                @(negedge clk);
                in_valid = 1'b0;
                rx_byte = BYTE_W'($urandom);
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid = 1'b1;
        rx_byte = b;
        do @(posedge clk); while (!in_ready);
        board.take_byte(b);
        bytes_sent++;
    endtask

    // Sends a frame with a correct checksum, or a corrupted one when asked.
    task automatic send_frame(input logic [BYTE_W-1:0] cmd, input logic [COUNT_W-1:0] count,
                              input bit bad_sum);
        logic [BYTE_W-1:0] sum;
        sum = cmd + count[31:24] + count[23:16] + count[15:8] + count[7:0];
        if (bad_sum)
            sum = sum ^ BYTE_W'($urandom_range(1, 255));
        push_byte(cmd);
        push_byte(count[31:24]);
        push_byte(count[23:16]);
        push_byte(count[15:8]);
        push_byte(count[7:0]);
        push_byte(sum);
    endtask

    // Picks a frame flavor and shapes its counter around the expected value.
    task automatic send_random_frame();
        frame_kind_t       kind;
        int                roll;
        logic [BYTE_W-1:0] cmd;
        logic [COUNT_W-1:0] exp_cnt;
        logic [COUNT_W-1:0] count;
        roll = $urandom_range(0, 99);
        if (roll < 45)      kind = FR_PASS;
        else if (roll < 57) kind = FR_LOW;
        else if (roll < 69) kind = FR_HIGH;
        else if (roll < 75) kind = FR_TOP;
        else if (roll < 88) kind = FR_BAD_SUM;
        else                kind = FR_NOISE;
        cmd = ($urandom_range(0, 19) == 0) ? 8'd0 : BYTE_W'($urandom_range(1, 255));
        exp_cnt = board.exp_counter;
        count = $urandom;
        case (kind)
            FR_PASS:
                count = ($urandom_range(0, 3) == 0) ? exp_cnt + 1 : exp_cnt;
            FR_LOW:
                if (exp_cnt == 0)
                    count = exp_cnt;
                else if ($urandom_range(0, 1) == 0)
                    count = exp_cnt - 1;
                else
                    count = count % exp_cnt;
            FR_HIGH:
                case ($urandom_range(0, 2))
                    0: count = exp_cnt + 2;
                    1: count = exp_cnt + $urandom_range(3, 1000);
                    default: ;
                endcase
            FR_TOP:
                count = 32'hffff_ffff - $urandom_range(0, 3);
            default: ;
        endcase
        if (kind == FR_NOISE)
            repeat (6) push_byte(BYTE_W'($urandom));
        else
            send_frame(cmd, count, kind == FR_BAD_SUM);
    endtask

    // Upper bound on run length.
    initial
    begin
        #2_000_000;
        $display("FAIL e2e_frame_checker_top");
        $finish;
    end

    // Reset, directed frames, random frames, then drain.
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        rx_byte = '0;
        out_ready = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // A first good frame, a jump to the top, a safe command, and the counter wrap.
        send_frame(8'hff, 32'h0000_0000, 1'b0);
        send_frame(8'h80, 32'hffff_fffe, 1'b0);
        send_frame(8'h00, 32'hffff_ffff, 1'b0);
        send_frame(8'h7f, 32'hffff_ffff, 1'b0);

        while (bytes_sent < 850)
            send_random_frame();

        @(negedge clk);
        in_valid = 1'b0;
        while (board.owed.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (board.errors == 0)
            $display("PASS e2e_frame_checker_top");
        else
            $display("FAIL e2e_frame_checker_top");
        $finish;
    end

endmodule
